// ===== rtl/core/psvg_pkg.sv =====
// Shared types, constants and codes for the polyline stroke vertex generator.
`default_nettype none
package psvg_pkg;

  localparam int COORD_FRAC_BITS  = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int COORD_W          = 32;
  localparam int NORM_W           = 16;
  localparam int DIV_NUM_W        = 64;
  localparam int DIV_CNT_W        = 7;

  localparam logic [DIV_CNT_W-1:0] DIV_POS_ITERS = DIV_CNT_W'(COORD_FRAC_BITS + 32);
  localparam logic [DIV_CNT_W-1:0] DIV_NRM_ITERS = DIV_CNT_W'(NORMAL_FRAC_BITS + 1);
  localparam logic [NORM_W-1:0]    NORM_ONE      = NORM_W'(1 << NORMAL_FRAC_BITS);

  // register indexes on the configuration port
  localparam logic REG_SIZE_WIDTH  = 1'b0;
  localparam logic REG_SIZE_HEIGHT = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      component_end;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic                      continuation;
    logic                      run_last;
  } out_item_t;

  // one segment handed from front to back
  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic                      first;
    logic                      last;
  } job_t;

  typedef struct packed {
    logic [COORD_W-1:0] size_width;
    logic [COORD_W-1:0] size_height;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCALE,
    ST_SQA,
    ST_SQB,
    ST_SQRT,
    ST_DNX,
    ST_DNY,
    ST_DPOS,
    ST_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/psvg_front.sv =====
// Front part: holds the pending point and turns point pairs into segment jobs.
`default_nettype none
module psvg_front import psvg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     q_full,
  output logic          q_push,
  output job_t          q_job
);

  logic signed [COORD_W-1:0] pend_x_r, pend_y_r;
  logic                      pend_valid_r, pend_first_r;
  logic                      take;

  // a request needs queue space only when it closes a segment
  assign in_ready = !pend_valid_r || !q_full;
  assign take     = in_valid && in_ready;
  assign q_push   = take && pend_valid_r;

  always_comb begin
    q_job.x0    = pend_x_r;
    q_job.y0    = pend_y_r;
    q_job.x1    = in_item.point_x;
    q_job.y1    = in_item.point_y;
    q_job.first = pend_first_r;
    q_job.last  = in_item.component_end;
  end

  // pending point bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_first_r <= 1'b1;
      pend_x_r     <= '0;
      pend_y_r     <= '0;
    end else if (take) begin
      if (in_item.component_end) begin
        pend_valid_r <= 1'b0;
        pend_first_r <= 1'b1;
      end else begin
        pend_x_r     <= in_item.point_x;
        pend_y_r     <= in_item.point_y;
        pend_first_r <= !pend_valid_r;
        pend_valid_r <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/psvg_queue.sv =====
// Two-entry job queue between front and back.
`default_nettype none
module psvg_queue import psvg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head_job,
  output q_ctl_t    status
);

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign head_job     = mem_r[rd_ptr_r];
  assign status.push  = push;
  assign status.pop   = pop;
  assign status.full  = count_r == 2'd2;
  assign status.empty = count_r == 2'd0;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/psvg_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module psvg_div import psvg_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [COORD_W-1:0]   den,
  input  wire logic [DIV_CNT_W-1:0] iters,
  output logic                      done,
  output logic [DIV_NUM_W-1:0]      quo
);

  logic [COORD_W:0]     rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] num_r, quo_r;
  logic [COORD_W-1:0]   den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [COORD_W+1:0]   trial;
  logic                 ge;

  // high numerator bits preload the remainder; caller keeps them below den
  assign trial   = {rem_r, num_r[6'(cnt_r - DIV_CNT_W'(1))]};
  assign ge      = trial >= {2'b00, den_r};
  assign rem_nxt = ge ? (COORD_W+1)'(trial - {2'b00, den_r}) : trial[COORD_W:0];
  assign done    = done_r;
  assign quo     = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= (COORD_W+1)'(num >> iters);
      num_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/psvg_back.sv =====
// Back part: segment normal, position scaling and vertex emission.
`default_nettype none
module psvg_back import psvg_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire job_t      head_job,
  input  wire q_ctl_t    q_status,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [COORD_W:0]     ax_r, ay_r, m;
  logic                 dx_neg_r, dy_pos_r;
  logic [61:0]          sq_r, sq_y;
  logic [63:0]          v_r, res_r, bitv, trial;
  logic [4:0]           k_r;
  logic [COORD_W-1:0]   len_r;
  logic signed [NORM_W-1:0] nx_r, ny_r;
  logic signed [COORD_W-1:0] pos_r [4];
  logic [1:0]           pi_r;
  logic [2:0]           vi_r, total, kk;
  logic                 issued_r;
  logic                 out_valid_r;
  out_item_t            out_r, vtx;
  logic                 load_v;

  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [COORD_W-1:0]   div_den;
  logic [DIV_CNT_W-1:0] div_iters;

  logic signed [COORD_W-1:0] pos_src;
  logic [COORD_W-1:0]        pos_mag;
  logic                      pos_neg, pos_done;
  logic signed [COORD_W-1:0] pos_sat;
  logic [NORM_W-1:0]         nmag;
  logic signed [COORD_W:0]   dx, dy;

  psvg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .iters (div_iters),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign m     = (ax_r > ay_r) ? ax_r : ay_r;
  assign dx    = $signed({job_r.x1[COORD_W-1], job_r.x1}) - $signed({job_r.x0[COORD_W-1], job_r.x0});
  assign dy    = $signed({job_r.y1[COORD_W-1], job_r.y1}) - $signed({job_r.y0[COORD_W-1], job_r.y0});
  assign bitv  = 64'(1) << {k_r, 1'b0};
  assign trial = res_r + bitv;
  assign sq_y  = ay_r[30:0] * ay_r[30:0];

  // position operand chosen by pass index: x0, y0, x1, y1
  assign pos_src  = pi_r[1] ? (pi_r[0] ? job_r.y1 : job_r.x1)
                            : (pi_r[0] ? job_r.y0 : job_r.x0);
  assign pos_neg  = pos_src[COORD_W-1];
  assign pos_mag  = pos_neg ? COORD_W'(-pos_src) : COORD_W'(pos_src);
  assign pos_done = job_r.last ? (pi_r == 2'd3) : (pi_r == 2'd1);

  always_comb begin
    if (pos_neg) begin
      pos_sat = (div_quo > 64'h8000_0000) ? $signed(32'h8000_0000)
                                          : $signed(COORD_W'(-div_quo));
    end else begin
      pos_sat = (div_quo > 64'h7FFF_FFFF) ? $signed(32'h7FFF_FFFF)
                                          : $signed(COORD_W'(div_quo));
    end
  end

  assign nmag = (div_quo > 64'(NORM_ONE)) ? NORM_ONE : NORM_W'(div_quo);

  // divider operands per state
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = len_r;
    div_iters = DIV_NRM_ITERS;
    unique case (state_r)
      ST_DNX: begin
        div_start = !issued_r;
        div_num   = (64'(ay_r) << NORMAL_FRAC_BITS) + 64'(len_r >> 1);
      end
      ST_DNY: begin
        div_start = !issued_r;
        div_num   = (64'(ax_r) << NORMAL_FRAC_BITS) + 64'(len_r >> 1);
      end
      ST_DPOS: begin
        div_start = !issued_r;
        div_num   = 64'(pos_mag) << COORD_FRAC_BITS;
        div_den   = pi_r[0] ? cfg.size_height : cfg.size_width;
        div_iters = DIV_POS_ITERS;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // vertex selection
  assign total = (job_r.first ? 3'd4 : 3'd2) + (job_r.last ? 3'd2 : 3'd0);
  assign kk    = job_r.first ? vi_r : vi_r + 3'd2;

  always_comb begin
    vtx.pos_x        = kk[2] ? pos_r[2] : pos_r[0];
    vtx.pos_y        = kk[2] ? pos_r[3] : pos_r[1];
    vtx.continuation = (kk > 3'd1);
    vtx.run_last     = (vi_r == total - 3'd1);
    if (kk == 3'd0 || kk == 3'd3 || kk == 3'd5) begin
      vtx.normal_x = -nx_r;
      vtx.normal_y = -ny_r;
    end else begin
      vtx.normal_x = nx_r;
      vtx.normal_y = ny_r;
    end
  end

  assign load_v    = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign q_pop     = (state_r == ST_IDLE) && !q_status.empty;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (!q_status.empty) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = (dx == '0 && dy == '0) ? ST_DPOS : ST_SCALE;
      ST_SCALE: if (m[COORD_W] || m[COORD_W-1] || m[COORD_W-2]) state_nxt = ST_SQA;
      ST_SQA:   state_nxt = ST_SQB;
      ST_SQB:   state_nxt = ST_SQRT;
      ST_SQRT:  if (k_r == 5'd0) state_nxt = ST_DNX;
      ST_DNX:   if (div_done) state_nxt = ST_DNY;
      ST_DNY:   if (div_done) state_nxt = ST_DPOS;
      ST_DPOS:  if (div_done && pos_done) state_nxt = ST_EMIT;
      ST_EMIT:  if (load_v && vtx.run_last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (div_done)       issued_r <= 1'b0;
      else if (div_start) issued_r <= 1'b1;
      if (load_v)         out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (load_v) out_r <= vtx;
    unique case (state_r)
      ST_IDLE: begin
        job_r <= head_job;
        pi_r  <= 2'd0;
        vi_r  <= 3'd0;
      end
      ST_LOAD: begin
        ax_r     <= dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
        ay_r     <= dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
        dx_neg_r <= dx[COORD_W];
        dy_pos_r <= !dy[COORD_W] && (dy != '0);
        nx_r     <= '0;
        ny_r     <= '0;
      end
      ST_SCALE: begin
        if (m[COORD_W] || m[COORD_W-1]) begin
          ax_r <= ax_r >> 1;
          ay_r <= ay_r >> 1;
        end else if (!m[COORD_W-2]) begin
          ax_r <= ax_r << 1;
          ay_r <= ay_r << 1;
        end
      end
      ST_SQA: sq_r <= ax_r[30:0] * ax_r[30:0];
      ST_SQB: begin
        v_r   <= 64'(sq_r) + 64'(sq_y);
        res_r <= '0;
        k_r   <= 5'd31;
      end
      ST_SQRT: begin
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bitv;
        end else begin
          res_r <= res_r >> 1;
        end
        k_r <= k_r - 5'd1;
        if (k_r == 5'd0) begin
          len_r <= (v_r >= trial) ? COORD_W'((res_r >> 1) + bitv) : COORD_W'(res_r >> 1);
        end
      end
      ST_DNX: if (div_done) nx_r <= dy_pos_r ? -$signed(nmag) : $signed(nmag);
      ST_DNY: if (div_done) ny_r <= dx_neg_r ? -$signed(nmag) : $signed(nmag);
      ST_DPOS: begin
        if (div_done) begin
          pos_r[pi_r] <= pos_sat;
          pi_r        <= pi_r + 2'd1;
        end
      end
      ST_EMIT: if (load_v) vi_r <= vi_r + 3'd1;
      default: begin
        vi_r <= vi_r;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/polyline_stroke_vertex_gen.sv =====
// Top level: configuration registers, front, job queue and back.
// Usage:
//  Points enter on in_valid/in_ready/in_item, one request per point, with
//  component_end on the last point of a path component. Vertices leave on
//  out_valid/out_ready/out_item, run_last on the final vertex of a job.
//  The first point of a component is held; each later point closes a
//  segment job which the front pushes into a two-entry queue.
//  The back works one job at a time: normalising shift, squaring, square
//  root, two normal divides and two or four position divides that share
//  one bit-serial divider, then the vertices, plus a fetch and a load
//  step. A zero-length segment goes from the load straight to the
//  position divides, and a stalled receiver holds vertex emission.
//  The front keeps accepting while the queue has room, so a stalled
//  receiver backs up the output register, then the queue, then in_ready.
//  Width and height sit at byte addresses 0 and 4 of the APB-style port;
//  writes of zero are ignored. Reset restores both to 1.0, empties the
//  queue and drops any held point.
`default_nettype none
module polyline_stroke_vertex_gen import psvg_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire in_item_t     in_item,
  output logic              out_valid,
  input  wire logic         out_ready,
  output out_item_t         out_item,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t   cfg_r;
  logic   q_full, q_push;
  job_t   push_job, head_job;
  q_ctl_t q_status;
  logic   q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SIZE_HEIGHT) ? cfg_r.size_height : cfg_r.size_width;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_width  <= 32'h0001_0000;
      cfg_r.size_height <= 32'h0001_0000;
    end else if (psel && penable && pwrite && pwdata != '0) begin
      if (paddr[2] == REG_SIZE_WIDTH) cfg_r.size_width  <= pwdata;
      else                            cfg_r.size_height <= pwdata;
    end
  end

  assign q_full = q_status.full;

  psvg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  psvg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .status   (q_status)
  );

  psvg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head_job  (head_job),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== tb/sv/polyline_stroke_vertex_gen_test.sv =====
// Self-checking testbench for the polyline stroke vertex generator.
`default_nettype none
module polyline_stroke_vertex_gen_test;
  import psvg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Register byte addresses on the configuration port
  localparam logic [2:0] ADDR_WIDTH  = 3'(4 * REG_SIZE_WIDTH);
  localparam logic [2:0] ADDR_HEIGHT = 3'(4 * REG_SIZE_HEIGHT);

  // Scoreboard: predicts vertices for each point and checks them in order
  class stroke_scoreboard;
    logic [31:0] width_div, height_div;
    logic signed [32:0] held_x, held_y;
    bit held, held_opens;
    out_item_t vertex_q[$];
    int errors;

    function new();
      width_div = 32'h10000; height_div = 32'h10000;
      held = 0; held_opens = 1; held_x = 0; held_y = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] val);
      if (val == 0) return;
      if (addr == ADDR_WIDTH) width_div = val;
      else if (addr == ADDR_HEIGHT) height_div = val;
    endfunction

    // Divide by a size and saturate to signed 32 bits
    function logic [31:0] scaled(logic signed [32:0] p, logic [31:0] sz);
      logic [63:0] mag, q;
      mag = p < 0 ? 64'(-p) : 64'(p);
      q = (mag << COORD_FRAC_BITS) / {32'd0, sz};
      if (p < 0) return q > 64'h8000_0000 ? 32'h8000_0000 : 32'(-q);
      return q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    function logic [63:0] root(logic [63:0] v);
      logic [63:0] r, b;
      r = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b; r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function logic [15:0] unit_comp(logic [63:0] a, logic [63:0] len, bit neg);
      logic [63:0] q;
      q = ((a << NORMAL_FRAC_BITS) + (len >> 1)) / len;
      if (q > (64'd1 << NORMAL_FRAC_BITS)) q = 64'd1 << NORMAL_FRAC_BITS;
      return neg ? 16'(-q) : q[15:0];
    endfunction

    // Unit normal (-dy, dx)/length of a segment, zero for a degenerate one
    function void seg_unit(logic signed [33:0] dx, logic signed [33:0] dy,
                           output logic [15:0] nx, output logic [15:0] ny);
      logic [63:0] ax, ay, m, len;
      ax = dx < 0 ? 64'(-dx) : 64'(dx);
      ay = dy < 0 ? 64'(-dy) : 64'(dy);
      m = ax > ay ? ax : ay;
      nx = 0; ny = 0;
      if (m == 0) return;
      if (m >= (64'd1 << 31)) begin
        ax >>= 1; ay >>= 1; m >>= 1;
      end
      while (m < (64'd1 << 30)) begin
        ax <<= 1; ay <<= 1; m <<= 1;
      end
      len = root(ax * ax + ay * ay);
      if (len == 0) return;
      nx = unit_comp(ay, len, dy > 0);
      ny = unit_comp(ax, len, dx < 0);
    endfunction

    function void push_point(logic signed [32:0] x, logic signed [32:0] y,
                             logic [15:0] nx, logic [15:0] ny, bit opens);
      out_item_t v;
      v.pos_x = scaled(x, width_div);
      v.pos_y = scaled(y, height_div);
      v.run_last = 0;
      if (opens) begin
        v.normal_x = -nx; v.normal_y = -ny; v.continuation = 0; vertex_q.push_back(v);
        v.normal_x = nx;  v.normal_y = ny;  vertex_q.push_back(v);
      end
      v.continuation = 1;
      v.normal_x = nx;  v.normal_y = ny;  vertex_q.push_back(v);
      v.normal_x = -nx; v.normal_y = -ny; vertex_q.push_back(v);
    endfunction

    // Note an accepted point request
    function void note_point(in_item_t it);
      logic signed [32:0] x, y;
      logic [15:0] nx, ny;
      x = 33'(it.point_x); y = 33'(it.point_y);
      if (!held) begin
        if (!it.component_end) begin
          held_x = x; held_y = y; held = 1;
        end
        held_opens = 1;
        return;
      end
      seg_unit(34'(x) - 34'(held_x), 34'(y) - 34'(held_y), nx, ny);
      push_point(held_x, held_y, nx, ny, held_opens);
      if (it.component_end) begin
        push_point(x, y, nx, ny, 0);
        held = 0; held_opens = 1;
      end else begin
        held_x = x; held_y = y; held_opens = 0;
      end
      vertex_q[$].run_last = 1;
    endfunction

    // Check one accepted vertex against the oldest prediction
    function void check_vertex(out_item_t got);
      out_item_t exp;
      if (vertex_q.size() == 0) begin
        $display("%0t: unexpected vertex %h", $time, got);
        errors++;
        return;
      end
      exp = vertex_q.pop_front();
      if (got.pos_x !== exp.pos_x) begin
        $display("%0t: pos_x exp %h got %h", $time, exp.pos_x, got.pos_x); errors++;
      end
      if (got.pos_y !== exp.pos_y) begin
        $display("%0t: pos_y exp %h got %h", $time, exp.pos_y, got.pos_y); errors++;
      end
      if (got.normal_x !== exp.normal_x) begin
        $display("%0t: normal_x exp %h got %h", $time, exp.normal_x, got.normal_x);
        errors++;
      end
      if (got.normal_y !== exp.normal_y) begin
        $display("%0t: normal_y exp %h got %h", $time, exp.normal_y, got.normal_y);
        errors++;
      end
      if (got.continuation !== exp.continuation) begin
        $display("%0t: continuation exp %b got %b", $time, exp.continuation,
                 got.continuation);
        errors++;
      end
      if (got.run_last !== exp.run_last) begin
        $display("%0t: run_last exp %b got %b", $time, exp.run_last, got.run_last);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_item_t in_item;
  out_item_t out_item;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  stroke_scoreboard board;

  polyline_stroke_vertex_gen dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    board.write_reg(addr, val);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, bit last);
    in_item_t it;
    it.point_x = x; it.point_y = y; it.component_end = last;
    in_valid <= 1; in_item <= it;
    do @(posedge clk); while (!in_ready);
    board.note_point(it);
    if ($urandom_range(0, 3) != 0) begin
      in_valid <= 0;
      repeat (gap_len() + 1) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.vertex_q.size() != 0) @(posedge clk);
    // a single-point component pushes no job to the back; still allow a full job
    repeat (400) @(posedge clk);
  endtask

  function logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
      2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom)};
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 400)) - 200) << 12;
    endcase
  endfunction

  // Random component of 1 to 8 points
  task automatic send_component();
    int n;
    logic [31:0] x, y;
    n = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 8);
    x = rand_coord(); y = rand_coord();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        // repeated point gives a zero-length segment
      end else if ($urandom_range(0, 1)) begin
        x = rand_coord(); y = rand_coord();
      end else begin
        x = x + 32'($signed($urandom_range(0, 8192)) - 4096) * 32'd64;
        y = y + 32'($signed($urandom_range(0, 8192)) - 4096) * 32'd64;
      end
      send_point(x, y, i == n - 1);
    end
  endtask

  // Receiver with random stalls
  initial begin
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) board.check_vertex(out_item);
      if ($urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        repeat (gap_len() + 1) @(posedge clk);
        out_ready <= 1;
      end else out_ready <= 1;
    end
  end

  initial begin
    int sent;
    board = new();
    rst_n = 0; in_valid = 0; in_item = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: default sizes, extremes, zero-length, lone point, two points
    send_point(32'h0001_0000, 32'h0002_0000, 0);
    send_point(32'h0004_0000, 32'h0006_0000, 1);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_point(32'hFFFF_FFFF, 32'h0000_0000, 1);
    send_point(32'h1234_5678, 32'h0000_0001, 1);
    send_point(32'h0000_0000, 32'h0000_0000, 0);
    send_point(32'h0000_0000, 32'h0000_0000, 1);
    send_point(32'h0000_0001, 32'hFFFF_FFFF, 0);
    send_point(32'h0000_0000, 32'h0000_0000, 0);
    send_point(32'hFFFF_0000, 32'h0001_0000, 1);
    drain();

    // Small divisors saturate; zero writes ignored
    write_reg(ADDR_WIDTH, 32'h0000_0001);
    write_reg(ADDR_HEIGHT, 32'h0000_0001);
    write_reg(ADDR_WIDTH, 32'h0000_0000);
    send_point(32'h0000_0001, 32'hFFFF_FFFF, 0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1);
    drain();
    write_reg(ADDR_WIDTH, 32'hFFFF_FFFF);
    write_reg(ADDR_HEIGHT, 32'hFFFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_point(32'h1000_0000, 32'hF000_0000, 1);
    drain();

    // Random phases with varied sizes
    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(ADDR_WIDTH, 32'h10000); write_reg(ADDR_HEIGHT, 32'h10000); end
        1: begin write_reg(ADDR_WIDTH, $urandom_range(1, 16));
                 write_reg(ADDR_HEIGHT, $urandom); end
        2: begin write_reg(ADDR_WIDTH, $urandom | 32'h1);
                 write_reg(ADDR_HEIGHT, $urandom_range(32'h100, 32'h100000)); end
        3: begin write_reg(ADDR_WIDTH, 32'hFFFF_FFFF); write_reg(ADDR_HEIGHT, 32'h1); end
        default: begin write_reg(ADDR_WIDTH, $urandom_range(32'h8000, 32'h40000));
                       write_reg(ADDR_HEIGHT, $urandom_range(32'h8000, 32'h40000)); end
      endcase
      while (sent < (ph + 1) * 100) begin
        send_component();
        sent = sent + 5;
        if ($urandom_range(0, 40) == 0) begin
          in_valid <= 0;
          do @(posedge clk); while (board.vertex_q.size() != 0);
        end
      end
      drain();
    end

    if (board.errors == 0 && board.vertex_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire

// ===== polyline_stroke_vertex_gen.f =====
rtl/core/psvg_pkg.sv
rtl/core/psvg_front.sv
rtl/core/psvg_queue.sv
rtl/core/psvg_div.sv
rtl/core/psvg_back.sv
rtl/core/polyline_stroke_vertex_gen.sv
tb/sv/polyline_stroke_vertex_gen_test.sv
